[hw/rtl/smcw_pkg.sv]
// Package for the form mismatch correction watchdog.
// Correction codes, register indexes, reset values and latency-grace constants.
// No dependencies.
`default_nettype none

package smcw_pkg;

	typedef enum logic [1:0] {
		CORR_NONE  = 2'd0,
		CORR_START = 2'd1,
		CORR_FORCE = 2'd2
	} corr_t;

	typedef enum logic [1:0] {
		REG_MAX_TRANSITION = 2'd0,
		REG_FAILED_SWITCH  = 2'd1,
		REG_MISMATCH       = 2'd2
	} reg_idx_t;

	localparam int unsigned RegW  = 16;
	localparam int unsigned FrameW = 32;
	localparam int unsigned PingW = 16;

	localparam logic [RegW-1:0] MaxTransitionReset = 16'd120;
	localparam logic [RegW-1:0] FailedSwitchReset  = 16'd30;
	localparam logic [RegW-1:0] MismatchReset      = 16'd10;

	// grace = clamp(ping*60/1000 + 8, 8, 32); ping >= 400 saturates at 32
	localparam logic [5:0]       GraceMin   = 6'd8;
	localparam logic [5:0]       GraceMax   = 6'd32;
	localparam logic [PingW-1:0] PingSat    = 16'd400;
	// floor(x/50) == (x*1311) >> 16 for x < 1200
	localparam logic [10:0]      Recip50    = 11'd1311;

endpackage

`default_nettype wire

[hw/rtl/state_mismatch_correction_watchdog.sv]
// Form mismatch correction watchdog, top level.
// Input register, decision logic on registered state, output register.
// Depends on smcw_pkg.
`default_nettype none

// channel   direction  handshake              payload
// in        request    in_valid / in_stall    frame_stamp, desired_form, actual_form,
//                                             entering, leaving, ping_ms
// out       result     out_valid / out_stall  correction
// cfg       write      cfg_we                 cfg_index, cfg_data
//
// One request per cycle while out_stall is low; results pass the input and output registers.
// The state update is done in the cycle a request moves from the input register to
// the output register, so consecutive frames see each other's state.
// Reset clears all tracking state and loads the register reset values.
// out_stall holds the output register; in_stall rises only when both registers are full.

module state_mismatch_correction_watchdog (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [31:0]                frame_stamp,
	input  wire logic                       desired_form,
	input  wire logic                       actual_form,
	input  wire logic                       entering,
	input  wire logic                       leaving,
	input  wire logic signed [15:0]         ping_ms,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [1:0]                      correction,
	input  wire logic                       cfg_we,
	input  wire logic [1:0]                 cfg_index,
	input  wire logic [15:0]                cfg_data
);
	import smcw_pkg::*;

	logic [RegW-1:0] max_trans_q, failed_sw_q, mismatch_q;

	logic                valid_s1;
	logic [FrameW-1:0]   now_s1;
	logic                want_s1, have_s1, ent_s1, lev_s1;
	logic [PingW-1:0]    ping_s1;

	logic                trans_active_q, trans_seen_q, trans_target_q;
	logic [FrameW-1:0]   trans_start_q, trans_last_q;
	logic                mismatch_flag_q, attempt_flag_q;
	logic [FrameW-1:0]   mismatch_start_q, attempt_start_q;

	logic                trans_active_d, trans_seen_d, trans_target_d;
	logic [FrameW-1:0]   trans_start_d, trans_last_d;
	logic                mismatch_flag_d, attempt_flag_d;
	logic [FrameW-1:0]   mismatch_start_d, attempt_start_d;
	corr_t               corr_d;
	corr_t               corr_q;

	logic                advance;
	logic                moving;
	logic [10:0]         ping3;
	logic [21:0]         quot_prod;
	logic [5:0]          grace;
	logic [FrameW-1:0]   dt_trans, dt_last, dt_attempt, dt_mismatch;
	logic [FrameW-1:0]   mis_start_eff;

	assign advance  = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign correction = corr_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_trans_q <= MaxTransitionReset;
			failed_sw_q <= FailedSwitchReset;
			mismatch_q  <= MismatchReset;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_MAX_TRANSITION: max_trans_q <= cfg_data;
				REG_FAILED_SWITCH:  failed_sw_q <= cfg_data;
				REG_MISMATCH:       mismatch_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			now_s1  <= frame_stamp;
			want_s1 <= desired_form;
			have_s1 <= actual_form;
			ent_s1  <= entering;
			lev_s1  <= leaving;
			ping_s1 <= ping_ms;
		end
	end

	// ping grace term, ping*60/1000 == floor(3*ping/50) for 0 <= ping < 400
	assign ping3     = {2'b00, ping_s1[8:0]} + {1'b0, ping_s1[8:0], 1'b0};
	assign quot_prod = {11'd0, ping3} * {11'd0, Recip50};

	always_comb begin
		if (ping_s1[PingW-1]) begin
			grace = GraceMin;
		end else if (ping_s1 >= PingSat) begin
			grace = GraceMax;
		end else begin
			grace = GraceMin + quot_prod[21:16];
		end
	end

	always_comb begin
		moving = ent_s1 || lev_s1;

		trans_active_d   = moving;
		trans_seen_d     = trans_seen_q;
		trans_target_d   = trans_target_q;
		trans_start_d    = trans_start_q;
		trans_last_d     = trans_last_q;
		mismatch_flag_d  = mismatch_flag_q;
		mismatch_start_d = mismatch_start_q;
		attempt_flag_d   = attempt_flag_q;
		attempt_start_d  = attempt_start_q;
		corr_d           = CORR_NONE;

		if (moving) begin
			if (!trans_active_q || (trans_target_q != ent_s1)) begin
				trans_start_d = now_s1;
			end
			trans_seen_d   = 1'b1;
			trans_target_d = ent_s1;
			trans_last_d   = now_s1;
		end

		dt_trans      = now_s1 - trans_start_d;
		dt_last       = now_s1 - trans_last_d;
		dt_attempt    = now_s1 - attempt_start_q;
		mis_start_eff = mismatch_flag_q ? mismatch_start_q : now_s1;
		dt_mismatch   = now_s1 - mis_start_eff;

		if ((have_s1 == want_s1) && !moving) begin
			mismatch_flag_d = 1'b0;
			attempt_flag_d  = 1'b0;
		end else if (moving) begin
			if (dt_trans >= {16'd0, max_trans_q}) begin
				corr_d = CORR_FORCE;
			end
		end else if (trans_seen_d && !attempt_flag_q && (trans_target_d == have_s1) &&
				(dt_last <= {26'd0, grace})) begin
			corr_d = CORR_NONE;
		end else if (attempt_flag_q) begin
			if (dt_attempt >= {16'd0, failed_sw_q}) begin
				corr_d = CORR_FORCE;
			end
		end else begin
			mismatch_flag_d  = 1'b1;
			mismatch_start_d = mis_start_eff;
			if (dt_mismatch >= {16'd0, mismatch_q}) begin
				attempt_flag_d  = 1'b1;
				attempt_start_d = now_s1;
				corr_d          = CORR_START;
			end
		end

		// force drops all tracking state
		if (corr_d == CORR_FORCE) begin
			trans_active_d   = 1'b0;
			trans_seen_d     = 1'b0;
			trans_target_d   = 1'b0;
			trans_start_d    = '0;
			trans_last_d     = '0;
			mismatch_flag_d  = 1'b0;
			mismatch_start_d = '0;
			attempt_flag_d   = 1'b0;
			attempt_start_d  = '0;
		end
	end

	// tracking state, updated as a request leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trans_active_q   <= 1'b0;
			trans_seen_q     <= 1'b0;
			trans_target_q   <= 1'b0;
			trans_start_q    <= '0;
			trans_last_q     <= '0;
			mismatch_flag_q  <= 1'b0;
			mismatch_start_q <= '0;
			attempt_flag_q   <= 1'b0;
			attempt_start_q  <= '0;
		end else if (advance) begin
			trans_active_q   <= trans_active_d;
			trans_seen_q     <= trans_seen_d;
			trans_target_q   <= trans_target_d;
			trans_start_q    <= trans_start_d;
			trans_last_q     <= trans_last_d;
			mismatch_flag_q  <= mismatch_flag_d;
			mismatch_start_q <= mismatch_start_d;
			attempt_flag_q   <= attempt_flag_d;
			attempt_start_q  <= attempt_start_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!out_valid || !out_stall) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			corr_q <= corr_d;
		end
	end

endmodule

`default_nettype wire
